>>> rtl/core/hdba_pkg.sv
// Shared types and constants for the half-duplex bus priority arbiter.
// No dependencies; imported by the core, the queue pointer file and the checker.
`timescale 1ns / 1ps
`default_nettype none

package hdba_pkg;

	// result event codes
	localparam logic [2:0] EV_GRANT_NOW = 3'd0;
	localparam logic [2:0] EV_QUEUED    = 3'd1;
	localparam logic [2:0] EV_REJECTED  = 3'd2;
	localparam logic [2:0] EV_RELEASED  = 3'd3;
	localparam logic [2:0] EV_REL_ERROR = 3'd4;
	localparam logic [2:0] EV_GRANT_Q   = 3'd5;

	// input mode codes
	localparam logic MODE_REQUEST = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	// directions
	localparam logic SENDER   = 1'b0;
	localparam logic RECEIVER = 1'b1;

	// configuration
	localparam logic [3:0] CAP_RESET   = 4'd3;
	localparam logic       REG_BUS_CAP = 1'b0;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_WAIT = 3'b100
	} state_t;

	// queue operation: queue number is {direction, priority}
	typedef struct packed {
		logic       push;
		logic       pop;
		logic [1:0] qsel;
	} qop_t;

	// per-queue status flags
	typedef struct packed {
		logic [3:0] nonempty;
		logic [3:0] full;
	} qstat_t;

endpackage

`default_nettype wire

>>> rtl/core/hdba_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies; holds the waiting task tags of all four queues.
`timescale 1ns / 1ps
`default_nettype none

module hdba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read, read data holds between reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/hdba_qptr.sv
// Head, tail and fill registers of the four waiter queues.
// Depends on hdba_pkg for the operation and status structs.
`timescale 1ns / 1ps
`default_nettype none

module hdba_qptr #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire hdba_pkg::qop_t                 op,
	output hdba_pkg::qstat_t                    stat,
	output logic [$clog2(QUEUE_DEPTH)-1:0]      head_idx,
	output logic [$clog2(QUEUE_DEPTH)-1:0]      tail_idx
);
	import hdba_pkg::*;

	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [QW-1:0] LAST_IDX = QW'(QUEUE_DEPTH - 1);
	localparam logic [FW-1:0] FULL_FILL = FW'(QUEUE_DEPTH);

	logic [QW-1:0] head_q [4];
	logic [QW-1:0] tail_q [4];
	logic [FW-1:0] fill_q [4];

	function automatic logic [QW-1:0] next_idx(input logic [QW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	// status flags per queue
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			stat.nonempty[k] = (fill_q[k] != '0);
			stat.full[k]     = (fill_q[k] == FULL_FILL);
		end
	end

	assign head_idx = head_q[op.qsel];
	assign tail_idx = tail_q[op.qsel];

	// pointer and fill update, one operation per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) begin
				head_q[k] <= '0;
				tail_q[k] <= '0;
				fill_q[k] <= '0;
			end
		end else if (op.push) begin
			tail_q[op.qsel] <= next_idx(tail_q[op.qsel]);
			fill_q[op.qsel] <= fill_q[op.qsel] + 1'b1;
		end else if (op.pop) begin
			head_q[op.qsel] <= next_idx(head_q[op.qsel]);
			fill_q[op.qsel] <= fill_q[op.qsel] - 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/half_duplex_bus_priority_arbiter_core.sv
// Half-duplex bus priority arbiter core: grants bus slots to tasks that all
// run in one direction, and parks the rest in four FIFO queues (high and
// normal priority per direction) whose tags live in one synchronous RAM.
// Input channel (in_valid/in_stall): mode 0 requests a slot, mode 1 releases
// one. Output channel (out_valid/out_stall): one result per item, or two when
// a release admits a waiter (release with last=0, then the grant with last=1).
// Sequence: an item is taken in the idle cycle, executed in the next, where
// its first result is loaded into the output register. A plain item passes
// through IDLE and EXEC; a release that admits a waiter also passes through
// WAIT, where the RAM read of the queue head gives the grant. The output
// register lets the next item be taken while a result still waits.
// A stalled output holds its result; execution waits for the slot to free.
// Capacity lives in an APB register at byte 0 (reset 3, 0 acts as 1).
// Reset empties the bus and all queues and sets the direction to sender; the
// tag RAM is not cleared, since only entries written before are ever read.
// Depends on hdba_pkg, hdba_ram and hdba_qptr.
`timescale 1ns / 1ps
`default_nettype none

module half_duplex_bus_priority_arbiter_core #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TAG_BITS    = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        mode,
	input  wire logic        direction,
	input  wire logic        priority_req,
	input  wire logic [7:0]  task_tag,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [2:0]  event_res,
	output logic      [7:0]  grant_tag,
	output logic             grant_direction,
	output logic             grant_priority,
	output logic      [3:0]  slots_used,
	output logic             last
);
	import hdba_pkg::*;

	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int AW = QW + 2;
	localparam int TW = (TAG_BITS > 8) ? TAG_BITS : 8;

	// configuration register
	logic [3:0] cap_q;
	logic [3:0] eff_cap;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BUS_CAP) ? {28'd0, cap_q} : 32'd0;
	assign eff_cap = (cap_q == 4'd0) ? 4'd1 : cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == REG_BUS_CAP)) begin
			cap_q <= pwdata[3:0];
		end
	end

	// sequencer and bus state
	state_t state_q;
	logic [3:0] bus_cnt_q;
	logic       bus_dir_q;

	// latched input item
	logic                mode_q;
	logic                dir_q;
	logic                prio_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [TW-1:0]       tag_in_ext;

	// waiter attributes for the second result
	logic wdir_q;
	logic wprio_q;

	// output register
	logic       out_valid_q;
	logic [2:0] ev_q;
	logic [7:0] gtag_q;
	logic       gdir_q;
	logic       gprio_q;
	logic [3:0] slots_q;
	logic       last_q;

	assign in_stall        = (state_q != ST_IDLE);
	assign out_valid       = out_valid_q;
	assign event_res       = ev_q;
	assign grant_tag       = gtag_q;
	assign grant_direction = gdir_q;
	assign grant_priority  = gprio_q;
	assign slots_used      = slots_q;
	assign last            = last_q;

	assign tag_in_ext = TW'(task_tag);

	// queue pointers and tag memory
	qop_t                qop;
	qstat_t              qstat;
	logic [QW-1:0]       head_idx;
	logic [QW-1:0]       tail_idx;
	logic                ram_we;
	logic                ram_re;
	logic [AW-1:0]       ram_addr;
	logic [TAG_BITS-1:0] ram_rdata;
	logic [TW-1:0]       ram_rdata_ext;

	hdba_qptr #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_qptr (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (qop),
		.stat    (qstat),
		.head_idx(head_idx),
		.tail_idx(tail_idx)
	);

	hdba_ram #(
		.WIDTH(TAG_BITS),
		.DEPTH(4 * (1 << QW))
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(tag_q),
		.rdata(ram_rdata)
	);

	assign ram_rdata_ext = TW'(ram_rdata);

	// admission checks
	logic       out_free;
	logic       req_adm;
	logic [1:0] req_qn;
	logic [3:0] cnt_dec;
	logic [3:0] cand_ok;
	logic [1:0] cand_qn [4];
	logic       pick_ok;
	logic [1:0] pick_qn;

	assign out_free = !out_valid_q || !out_stall;
	assign req_adm  = (bus_cnt_q < eff_cap) && ((bus_cnt_q == 4'd0) || (dir_q == bus_dir_q));
	assign req_qn   = {dir_q, prio_q};
	assign cnt_dec  = bus_cnt_q - 4'd1;

	// candidates in order: high same, normal same, high other, normal other
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			cand_qn[k] = {dir_q ^ (k >= 2), (k % 2 == 0)};
			cand_ok[k] = qstat.nonempty[cand_qn[k]] && (cnt_dec < eff_cap)
				&& ((cnt_dec == 4'd0) || (cand_qn[k][1] == bus_dir_q));
		end
	end

	// first admissible waiter
	always_comb begin
		pick_ok = 1'b1;
		pick_qn = cand_qn[3];
		if (cand_ok[0]) begin
			pick_qn = cand_qn[0];
		end else if (cand_ok[1]) begin
			pick_qn = cand_qn[1];
		end else if (cand_ok[2]) begin
			pick_qn = cand_qn[2];
		end else if (!cand_ok[3]) begin
			pick_ok = 1'b0;
		end
	end

	// queue and memory control for the execute cycle
	logic exec_go;
	logic wait_go;
	logic do_push;
	logic do_pop;

	assign exec_go = (state_q == ST_EXEC) && out_free;
	assign wait_go = (state_q == ST_WAIT) && out_free;
	assign do_push = exec_go && (mode_q == MODE_REQUEST) && !req_adm && !qstat.full[req_qn];
	assign do_pop  = exec_go && (mode_q == MODE_RELEASE) && (bus_cnt_q != 4'd0) && pick_ok;

	assign qop.push = do_push;
	assign qop.pop  = do_pop;
	assign qop.qsel = (mode_q == MODE_RELEASE) ? pick_qn : req_qn;

	assign ram_we   = do_push;
	assign ram_re   = do_pop;
	assign ram_addr = {qop.qsel, (mode_q == MODE_RELEASE) ? head_idx : tail_idx};

	// output valid: set when a result is loaded, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_go || wait_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// control state: sequencer and bus occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bus_cnt_q   <= 4'd0;
			bus_dir_q   <= SENDER;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (out_free) begin
						if (mode_q == MODE_REQUEST) begin
							state_q <= ST_IDLE;
							if (req_adm) begin
								bus_cnt_q <= bus_cnt_q + 4'd1;
								bus_dir_q <= dir_q;
							end
						end else if (bus_cnt_q != 4'd0 && pick_ok) begin
							bus_dir_q <= pick_qn[1];
							state_q   <= ST_WAIT;
						end else begin
							state_q <= ST_IDLE;
							if (bus_cnt_q != 4'd0) begin
								bus_cnt_q <= cnt_dec;
							end
						end
					end
				end
				ST_WAIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// stored tag widened or cut to the 8-bit result field
	function automatic logic [7:0] tag_ext8(input logic [TAG_BITS-1:0] t);
		logic [TW-1:0] w;
		w = TW'(t);
		return w[7:0];
	endfunction

	// latched item and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			mode_q <= mode;
			dir_q  <= direction;
			prio_q <= priority_req;
			tag_q  <= tag_in_ext[TAG_BITS-1:0];
		end
		if (exec_go) begin
			gtag_q  <= tag_ext8(tag_q);
			gdir_q  <= dir_q;
			gprio_q <= prio_q;
			if (mode_q == MODE_REQUEST) begin
				last_q <= 1'b1;
				if (req_adm) begin
					ev_q    <= EV_GRANT_NOW;
					slots_q <= bus_cnt_q + 4'd1;
				end else if (qstat.full[req_qn]) begin
					ev_q    <= EV_REJECTED;
					slots_q <= bus_cnt_q;
				end else begin
					ev_q    <= EV_QUEUED;
					slots_q <= bus_cnt_q;
				end
			end else if (bus_cnt_q == 4'd0) begin
				ev_q    <= EV_REL_ERROR;
				slots_q <= bus_cnt_q;
				last_q  <= 1'b1;
			end else begin
				ev_q    <= EV_RELEASED;
				slots_q <= cnt_dec;
				last_q  <= !pick_ok;
				wdir_q  <= pick_qn[1];
				wprio_q <= pick_qn[0];
			end
		end else if (wait_go) begin
			ev_q    <= EV_GRANT_Q;
			gtag_q  <= ram_rdata_ext[7:0];
			gdir_q  <= wdir_q;
			gprio_q <= wprio_q;
			slots_q <= bus_cnt_q;
			last_q  <= 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/hdba_checker.sv
// Port-level checker for the half-duplex bus priority arbiter core.
// Depends on hdba_pkg; bound to half_duplex_bus_priority_arbiter_core below.
`timescale 1ns / 1ps
`default_nettype none

module hdba_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [2:0] event_res,
	input wire logic [7:0] grant_tag,
	input wire logic       grant_direction,
	input wire logic       grant_priority,
	input wire logic [3:0] slots_used,
	input wire logic       last
);
	import hdba_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(grant_tag)
			&& $stable(grant_direction) && $stable(grant_priority)
			&& $stable(slots_used) && $stable(last))
		else $error("stalled result changed");

	// single-result events and the queue grant always close their item
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_GRANT_NOW || event_res == EV_QUEUED
			|| event_res == EV_REJECTED || event_res == EV_REL_ERROR
			|| event_res == EV_GRANT_Q) |-> last)
		else $error("single result without last");

	// a release that is not last is followed at once by the queue grant
	a_release_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && event_res == EV_RELEASED && !last
			|=> out_valid && event_res == EV_GRANT_Q)
		else $error("release not followed by queue grant");

	// a grant always leaves at least one task on the bus
	a_grant_slots: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_GRANT_NOW || event_res == EV_GRANT_Q)
			|-> slots_used != 4'd0)
		else $error("grant with empty bus");

endmodule

bind half_duplex_bus_priority_arbiter_core hdba_checker u_hdba_checker (.*);

`default_nettype wire
